### hdl/c6502eu_pkg.sv
// Shared types and constants for the 6502-style execute unit.
package c6502eu_pkg;

  // Operation codes carried in req_type
  typedef enum logic [5:0] {
    OP_ORA = 6'd0,  OP_AND = 6'd1,  OP_EOR = 6'd2,  OP_ADC = 6'd3,
    OP_SBC = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
    OP_BIT = 6'd8,  OP_LDA = 6'd9,  OP_LDX = 6'd10, OP_LDY = 6'd11,
    OP_STA = 6'd12, OP_STX = 6'd13, OP_STY = 6'd14, OP_ASL = 6'd15,
    OP_LSR = 6'd16, OP_ROL = 6'd17, OP_ROR = 6'd18, OP_INC = 6'd19,
    OP_DEC = 6'd20, OP_INX = 6'd21, OP_INY = 6'd22, OP_DEX = 6'd23,
    OP_DEY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TXA = 6'd27,
    OP_TYA = 6'd28, OP_TSX = 6'd29, OP_TXS = 6'd30, OP_CLC = 6'd31,
    OP_SEC = 6'd32, OP_CLI = 6'd33, OP_SEI = 6'd34, OP_CLV = 6'd35,
    OP_CLD = 6'd36, OP_SED = 6'd37, OP_PHA = 6'd38, OP_PHP = 6'd39,
    OP_PLA = 6'd40, OP_PLP = 6'd41, OP_NOP = 6'd42
  } op_e_t;

  // Status bit positions
  localparam int unsigned FLAG_N = 7;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_C = 0;

  // Bits 5 and 4 always read as one
  localparam logic [7:0] FLAG_FIXED = 8'h30;
  localparam logic [7:0] SP_RESET   = 8'hFD;
  localparam logic [7:0] ST_RESET   = 8'h34;

  typedef struct packed {
    logic [5:0] req_type;
    logic [7:0] operand;
    logic       on_memory;
  } in_req_t;

  typedef struct packed {
    logic [7:0] store_data;
    logic       store_enable;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] status_out;
  } out_req_t;

  // Programmer-visible register file
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] st;
  } arch_t;

endpackage

### hdl/c6502eu_alu.sv
// Combinational operation datapath: register file in, next register file and result out.
module c6502eu_alu (
  input  c6502eu_pkg::in_req_t  req,
  input  c6502eu_pkg::arch_t    arch,
  output c6502eu_pkg::arch_t    arch_nxt,
  output c6502eu_pkg::out_req_t res
);
  import c6502eu_pkg::*;

  op_e_t       op;
  logic [7:0]  m;
  logic        carry;
  logic [7:0]  cmp_reg;
  logic [7:0]  addend;
  logic        cin;
  logic [8:0]  sum;
  logic        ovf;
  logic [7:0]  sh_in;
  logic [7:0]  sh_left;
  logic [7:0]  sh_right;
  logic [7:0]  inc_m;
  logic [7:0]  dec_m;
  logic        set_nz;
  logic [7:0]  nz_val;
  logic [7:0]  st;
  arch_t       nxt;
  logic [7:0]  sdata;
  logic        sen;

  assign op    = op_e_t'(req.req_type);
  assign m     = req.operand;
  assign carry = arch.st[FLAG_C];

  // Shared adder: ADC adds, SBC and the compares add the complement
  assign cmp_reg = (op == OP_CPX) ? arch.x : ((op == OP_CPY) ? arch.y : arch.acc);
  assign addend  = (op == OP_ADC) ? m : ~m;
  assign cin     = ((op == OP_ADC) || (op == OP_SBC)) ? carry : 1'b1;
  assign sum     = {1'b0, cmp_reg} + {1'b0, addend} + {8'd0, cin};
  assign ovf     = (cmp_reg[7] ^ sum[7]) & (addend[7] ^ sum[7]);

  // Shifter; carry fed in for the rotates
  assign sh_in    = req.on_memory ? m : arch.acc;
  assign sh_left  = {sh_in[6:0], (op == OP_ROL) ? carry : 1'b0};
  assign sh_right = {(op == OP_ROR) ? carry : 1'b0, sh_in[7:1]};

  assign inc_m = m + 8'd1;
  assign dec_m = m - 8'd1;

  always_comb begin
    nxt    = arch;
    st     = arch.st;
    set_nz = 1'b0;
    nz_val = 8'd0;
    sdata  = 8'd0;
    sen    = 1'b0;
    case (op)
      OP_ORA: begin nxt.acc = arch.acc | m; set_nz = 1'b1; nz_val = arch.acc | m; end
      OP_AND: begin nxt.acc = arch.acc & m; set_nz = 1'b1; nz_val = arch.acc & m; end
      OP_EOR: begin nxt.acc = arch.acc ^ m; set_nz = 1'b1; nz_val = arch.acc ^ m; end
      OP_ADC, OP_SBC: begin
        nxt.acc   = sum[7:0];
        st[FLAG_C] = sum[8];
        st[FLAG_V] = ovf;
        set_nz    = 1'b1;
        nz_val    = sum[7:0];
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        st[FLAG_C] = sum[8];
        set_nz    = 1'b1;
        nz_val    = sum[7:0];
      end
      OP_BIT: begin
        st[FLAG_Z] = ((arch.acc & m) == 8'd0);
        st[FLAG_V] = m[6];
        st[FLAG_N] = m[7];
      end
      OP_LDA: begin nxt.acc = m; set_nz = 1'b1; nz_val = m; end
      OP_LDX: begin nxt.x = m; set_nz = 1'b1; nz_val = m; end
      OP_LDY: begin nxt.y = m; set_nz = 1'b1; nz_val = m; end
      OP_STA: begin sdata = arch.acc; sen = 1'b1; end
      OP_STX: begin sdata = arch.x; sen = 1'b1; end
      OP_STY: begin sdata = arch.y; sen = 1'b1; end
      OP_ASL, OP_ROL: begin
        st[FLAG_C] = sh_in[7];
        set_nz    = 1'b1;
        nz_val    = sh_left;
        if (req.on_memory) begin
          sdata = sh_left;
          sen   = 1'b1;
        end else begin
          nxt.acc = sh_left;
        end
      end
      OP_LSR, OP_ROR: begin
        st[FLAG_C] = sh_in[0];
        set_nz    = 1'b1;
        nz_val    = sh_right;
        if (req.on_memory) begin
          sdata = sh_right;
          sen   = 1'b1;
        end else begin
          nxt.acc = sh_right;
        end
      end
      OP_INC: begin set_nz = 1'b1; nz_val = inc_m; sdata = inc_m; sen = 1'b1; end
      OP_DEC: begin set_nz = 1'b1; nz_val = dec_m; sdata = dec_m; sen = 1'b1; end
      OP_INX: begin nxt.x = arch.x + 8'd1; set_nz = 1'b1; nz_val = arch.x + 8'd1; end
      OP_INY: begin nxt.y = arch.y + 8'd1; set_nz = 1'b1; nz_val = arch.y + 8'd1; end
      OP_DEX: begin nxt.x = arch.x - 8'd1; set_nz = 1'b1; nz_val = arch.x - 8'd1; end
      OP_DEY: begin nxt.y = arch.y - 8'd1; set_nz = 1'b1; nz_val = arch.y - 8'd1; end
      OP_TAX: begin nxt.x = arch.acc; set_nz = 1'b1; nz_val = arch.acc; end
      OP_TAY: begin nxt.y = arch.acc; set_nz = 1'b1; nz_val = arch.acc; end
      OP_TXA: begin nxt.acc = arch.x; set_nz = 1'b1; nz_val = arch.x; end
      OP_TYA: begin nxt.acc = arch.y; set_nz = 1'b1; nz_val = arch.y; end
      OP_TSX: begin nxt.x = arch.sp; set_nz = 1'b1; nz_val = arch.sp; end
      OP_TXS: nxt.sp = arch.x;
      OP_CLC: st[FLAG_C] = 1'b0;
      OP_SEC: st[FLAG_C] = 1'b1;
      OP_CLI: st[FLAG_I] = 1'b0;
      OP_SEI: st[FLAG_I] = 1'b1;
      OP_CLV: st[FLAG_V] = 1'b0;
      OP_CLD: st[FLAG_D] = 1'b0;
      OP_SED: st[FLAG_D] = 1'b1;
      OP_PHA: begin sdata = arch.acc; sen = 1'b1; nxt.sp = arch.sp - 8'd1; end
      OP_PHP: begin sdata = arch.st | FLAG_FIXED; sen = 1'b1; nxt.sp = arch.sp - 8'd1; end
      OP_PLA: begin
        nxt.sp  = arch.sp + 8'd1;
        nxt.acc = m;
        set_nz  = 1'b1;
        nz_val  = m;
      end
      OP_PLP: begin nxt.sp = arch.sp + 8'd1; st = m; end
      default: ;
    endcase
    // N and Z from the result byte where the operation sets them
    if (set_nz) begin
      st[FLAG_N] = nz_val[7];
      st[FLAG_Z] = (nz_val == 8'd0);
    end
    nxt.st = st | FLAG_FIXED;
  end

  assign arch_nxt = nxt;

  always_comb begin
    res.store_data   = sdata;
    res.store_enable = sen;
    res.acc_out      = nxt.acc;
    res.x_out        = nxt.x;
    res.y_out        = nxt.y;
    res.sp_out       = nxt.sp;
    res.status_out   = nxt.st;
  end

endmodule

### hdl/cpu6502_execute_unit.sv
// Execute unit top level: request register, datapath, result register and register file.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_req  (req_type, operand, on_memory)
//   out_    | output    | out_valid/out_stall | out_req (store, registers, status)
//
// One request per cycle while out_stall is low; the accepted request is registered in
// the request register, passes the datapath and is registered in the result register.
// The register file updates as a request moves into the result register, so
// back-to-back requests see each other's effect with no bubble.
// Reset: A, X, Y cleared, SP = 0xFD, status = 0x34; both stages empty.
// A stalled result still leaves the request register free to take one more request.
module cpu6502_execute_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  c6502eu_pkg::in_req_t   in_req,
  output logic                   out_valid,
  input  logic                   out_stall,
  output c6502eu_pkg::out_req_t  out_req
);
  import c6502eu_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_req_t  s1_req_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  out_req_t out_req_r;
  arch_t    arch_r;
  arch_t    arch_nxt;
  out_req_t alu_res;
  logic     out_free;
  logic     adv;
  logic     in_acc;

  // Flow control between the two stages
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  c6502eu_alu u_alu (
    .req      (s1_req_r),
    .arch     (arch_r),
    .arch_nxt (arch_nxt),
    .res      (alu_res)
  );

  // Control state and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      arch_r      <= '{acc: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, st: ST_RESET};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        arch_r <= arch_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_req;
    end
    if (adv) begin
      out_req_r <= alu_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

`ifndef SYNTHESIS
  // Reported registers match the register file once a request retires
  a_result_matches_regs: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_req_r.acc_out == arch_r.acc) && (out_req_r.x_out == arch_r.x) &&
            (out_req_r.y_out == arch_r.y) && (out_req_r.sp_out == arch_r.sp) &&
            (out_req_r.status_out == arch_r.st))
    else $error("result registers differ from register file");

  // Register file moves only when a request retires
  a_regs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(arch_r))
    else $error("register file changed without a retiring request");

  // Unused status bits always read as one
  a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (arch_r.st & FLAG_FIXED) == FLAG_FIXED)
    else $error("status bits 5/4 not set");

  // A pending request never waits behind an empty result register
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("request held with result register empty");
`endif

endmodule

### sim/tb.sv
// Self-checking testbench for the 6502-style execute unit.
module tb;
  import c6502eu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 8;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  cpu6502_execute_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always #5 clk = ~clk;

  // Architectural mirror of the unit plus the queue of results still due
  class exec_mirror;
    logic [7:0]  acc, xr, yr, sp, st;
    out_req_t    due_results[$];
    int unsigned mismatches;

    function new();
      acc = '0;
      xr = '0;
      yr = '0;
      sp = SP_RESET;
      st = ST_RESET;
      mismatches = 0;
    endfunction

    function void set_nz(logic [7:0] v);
      st[FLAG_N] = v[7];
      st[FLAG_Z] = (v == 8'h00);
    endfunction

    function void compare_with(logic [7:0] rg, logic [7:0] m);
      logic [8:0] diff;
      diff = {1'b0, rg} - {1'b0, m};
      st[FLAG_C] = ~diff[8];
      set_nz(diff[7:0]);
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(in_req_t r);
      out_req_t   res;
      logic [8:0] sum;
      logic [7:0] m, v, sh;
      logic       c;
      res = '0;
      m = r.operand;
      c = st[FLAG_C];
      case (r.req_type)
        OP_ORA: begin acc = acc | m; set_nz(acc); end
        OP_AND: begin acc = acc & m; set_nz(acc); end
        OP_EOR: begin acc = acc ^ m; set_nz(acc); end
        OP_ADC: begin
          sum = {1'b0, acc} + {1'b0, m} + {8'd0, c};
          st[FLAG_C] = sum[8];
          st[FLAG_V] = (acc[7] ^ sum[7]) & (m[7] ^ sum[7]);
          acc = sum[7:0];
          set_nz(acc);
        end
        OP_SBC: begin
          sum = {1'b0, acc} - {1'b0, m} - {8'd0, ~c};
          st[FLAG_C] = ~sum[8];
          st[FLAG_V] = (acc[7] ^ sum[7]) & (~m[7] ^ sum[7]);
          acc = sum[7:0];
          set_nz(acc);
        end
        OP_CMP: compare_with(acc, m);
        OP_CPX: compare_with(xr, m);
        OP_CPY: compare_with(yr, m);
        OP_BIT: begin
          st[FLAG_Z] = ((acc & m) == 8'h00);
          st[FLAG_V] = m[6];
          st[FLAG_N] = m[7];
        end
        OP_LDA: begin acc = m; set_nz(m); end
        OP_LDX: begin xr = m; set_nz(m); end
        OP_LDY: begin yr = m; set_nz(m); end
        OP_STA: begin res.store_data = acc; res.store_enable = 1'b1; end
        OP_STX: begin res.store_data = xr; res.store_enable = 1'b1; end
        OP_STY: begin res.store_data = yr; res.store_enable = 1'b1; end
        OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
          v = r.on_memory ? m : acc;
          case (r.req_type)
            OP_ASL:  begin sh = {v[6:0], 1'b0}; st[FLAG_C] = v[7]; end
            OP_ROL:  begin sh = {v[6:0], c};    st[FLAG_C] = v[7]; end
            OP_LSR:  begin sh = {1'b0, v[7:1]}; st[FLAG_C] = v[0]; end
            default: begin sh = {c, v[7:1]};    st[FLAG_C] = v[0]; end
          endcase
          set_nz(sh);
          if (r.on_memory) begin
            res.store_data = sh;
            res.store_enable = 1'b1;
          end else begin
            acc = sh;
          end
        end
        OP_INC: begin
          sh = m + 8'd1;
          set_nz(sh);
          res.store_data = sh;
          res.store_enable = 1'b1;
        end
        OP_DEC: begin
          sh = m - 8'd1;
          set_nz(sh);
          res.store_data = sh;
          res.store_enable = 1'b1;
        end
        OP_INX: begin xr = xr + 8'd1; set_nz(xr); end
        OP_INY: begin yr = yr + 8'd1; set_nz(yr); end
        OP_DEX: begin xr = xr - 8'd1; set_nz(xr); end
        OP_DEY: begin yr = yr - 8'd1; set_nz(yr); end
        OP_TAX: begin xr = acc; set_nz(acc); end
        OP_TAY: begin yr = acc; set_nz(acc); end
        OP_TXA: begin acc = xr; set_nz(xr); end
        OP_TYA: begin acc = yr; set_nz(yr); end
        OP_TSX: begin xr = sp; set_nz(sp); end
        OP_TXS: sp = xr;
        OP_CLC: st[FLAG_C] = 1'b0;
        OP_SEC: st[FLAG_C] = 1'b1;
        OP_CLI: st[FLAG_I] = 1'b0;
        OP_SEI: st[FLAG_I] = 1'b1;
        OP_CLV: st[FLAG_V] = 1'b0;
        OP_CLD: st[FLAG_D] = 1'b0;
        OP_SED: st[FLAG_D] = 1'b1;
        // push stores first, then moves SP down
        OP_PHA: begin
          res.store_data = acc;
          res.store_enable = 1'b1;
          sp = sp - 8'd1;
        end
        OP_PHP: begin
          res.store_data = st | FLAG_FIXED;
          res.store_enable = 1'b1;
          sp = sp - 8'd1;
        end
        OP_PLA: begin
          sp = sp + 8'd1;
          acc = m;
          set_nz(m);
        end
        OP_PLP: begin
          sp = sp + 8'd1;
          st = m | FLAG_FIXED;
        end
        default: ;  // NOP and undefined codes
      endcase
      st = st | FLAG_FIXED;
      res.acc_out = acc;
      res.x_out = xr;
      res.y_out = yr;
      res.sp_out = sp;
      res.status_out = st;
      due_results.push_back(res);
    endfunction

    // Compare one retired result with the oldest outstanding expectation
    function void check_result(out_req_t got);
      out_req_t exp_res;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with no request outstanding: %h", got);
        return;
      end
      exp_res = due_results.pop_front();
      if (got.store_data !== exp_res.store_data || got.store_enable !== exp_res.store_enable ||
          got.acc_out !== exp_res.acc_out || got.x_out !== exp_res.x_out ||
          got.y_out !== exp_res.y_out || got.sp_out !== exp_res.sp_out ||
          got.status_out !== exp_res.status_out) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: exp sd=%h se=%b a=%h x=%h y=%h sp=%h p=%h",
                   exp_res.store_data, exp_res.store_enable, exp_res.acc_out,
                   exp_res.x_out, exp_res.y_out, exp_res.sp_out, exp_res.status_out);
          $display("       got sd=%h se=%b a=%h x=%h y=%h sp=%h p=%h",
                   got.store_data, got.store_enable, got.acc_out,
                   got.x_out, got.y_out, got.sp_out, got.status_out);
        end
      end
    endfunction
  endclass

  exec_mirror  mirror;
  int unsigned sent = 0;
  int unsigned retired = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  // Result side: random stalls, one long hold-off, and a quiet stretch
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      mirror.check_result(out_req);
      retired++;
      if (retired == 400)
        hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (retired >= 650 && retired < 950) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 20);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_req_t make_req(op_e_t op, logic [7:0] operand, logic mem);
    in_req_t r;
    r.req_type = op;
    r.operand = operand;
    r.on_memory = mem;
    return r;
  endfunction

  // Mostly defined operations, a few undefined codes, operands biased to edges
  function automatic in_req_t random_request();
    in_req_t r;
    if ($urandom_range(99) < 4)
      r.req_type = 6'($urandom_range((1 << $bits(r.req_type)) - 1, OP_NOP + 1));
    else
      r.req_type = 6'($urandom_range(OP_NOP));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       r.operand = 8'h00;
        1:       r.operand = 8'h7F;
        2:       r.operand = 8'h80;
        default: r.operand = 8'hFF;
      endcase
    end else begin
      r.operand = 8'($urandom_range(255));
    end
    r.on_memory = 1'($urandom_range(1));
    return r;
  endfunction

  // Offer one request, with random idle cycles ahead of it outside the quiet stretch
  task automatic issue_request(in_req_t r);
    if (sent < 600 || sent >= 900) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    mirror.note_request(r);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mirror.due_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    mirror = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: flag edges, binary arithmetic with D set, stack wrap, fixed status bits
    issue_request(make_req(OP_LDA, 8'h00, 1'b0));
    issue_request(make_req(OP_LDA, 8'h7F, 1'b0));
    issue_request(make_req(OP_ADC, 8'h01, 1'b0));
    issue_request(make_req(OP_SED, 8'h00, 1'b0));
    issue_request(make_req(OP_ADC, 8'h99, 1'b0));
    issue_request(make_req(OP_SEC, 8'h00, 1'b0));
    issue_request(make_req(OP_SBC, 8'hFF, 1'b0));
    issue_request(make_req(OP_CMP, mirror.acc, 1'b0));
    issue_request(make_req(OP_LDX, 8'hFF, 1'b0));
    issue_request(make_req(OP_TXS, 8'h00, 1'b0));
    issue_request(make_req(OP_PLA, 8'h00, 1'b0));
    issue_request(make_req(OP_PHP, 8'h00, 1'b0));
    issue_request(make_req(OP_PLP, 8'hFF, 1'b0));
    issue_request(make_req(OP_PLP, 8'h00, 1'b0));
    issue_request(make_req(OP_INC, 8'hFF, 1'b1));
    issue_request(make_req(OP_DEC, 8'h00, 1'b0));
    issue_request(make_req(OP_INX, 8'h00, 1'b0));
    issue_request(make_req(OP_DEX, 8'h00, 1'b0));
    issue_request(make_req(OP_ASL, 8'h80, 1'b1));
    issue_request(make_req(OP_ROR, 8'h00, 1'b0));
    issue_request(make_req(OP_LSR, 8'h01, 1'b1));
    issue_request(make_req(OP_STA, 8'hFF, 1'b1));
    issue_request(make_req(OP_BIT, 8'hC0, 1'b0));
    issue_request(make_req(OP_NOP, 8'hFF, 1'b1));
    issue_request(make_req(op_e_t'(OP_NOP + 1), 8'h55, 1'b1));
    issue_request('1);
    wait_drained();

    // Random traffic, with one full drain part way through
    repeat (1400) begin
      if (sent == 1000)
        wait_drained();
      issue_request(random_request());
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mirror.mismatches == 0 && mirror.due_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
hdl/c6502eu_pkg.sv
hdl/c6502eu_alu.sv
hdl/cpu6502_execute_unit.sv
sim/tb.sv
